@@ src/jamm_pkg.sv @@
// Shared types and constants for the joystick axis mode mapper.
// Used by every module of the block and by its checker; no dependencies.
`default_nettype none

package jamm_pkg;

  // Block dimensions
  localparam int NUM_AXES    = 6;
  localparam int NUM_BUTTONS = 16;
  localparam int MAP_ENTRIES = 10;
  localparam int VECTOR_LEN  = 10;
  localparam int NUM_PAIRS   = (MAP_ENTRIES + 1) / 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Field widths
  localparam int SAMPLE_W = 16;
  localparam int INDEX_W  = 4;
  localparam int DZ_W     = 15;
  localparam int BTN_W    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Gripper entry and its closed value (0.8 in Q7.8)
  localparam logic [INDEX_W-1:0]         GRIP_INDEX        = 4'd9;
  localparam logic signed [SAMPLE_W-1:0] GRIP_CLOSED_VALUE = 16'sd205;
  localparam logic [INDEX_W-1:0]         LAST_INDEX        = INDEX_W'(VECTOR_LEN - 1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEADZONE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRIP_SEL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_PAIR_0 = 3'd2;

  // One packed mapping entry, bit 0 is valid
  typedef struct packed {
    logic [3:0]                 spare;
    logic signed [SAMPLE_W-1:0] gain;
    logic [INDEX_W-1:0]         target;
    logic [2:0]                 axis;
    logic [BTN_W-1:0]           mode;
    logic                       valid;
  } map_entry_t;

  typedef map_entry_t [MAP_ENTRIES-1:0] map_table_t;

  // Classified snapshot handed from front to back
  typedef struct packed {
    logic                               connected;
    logic                               mode_valid;
    logic [BTN_W-1:0]                   mode;
    logic                               grip_closed;
    logic [NUM_AXES-1:0][SAMPLE_W-1:0]  axes;
    logic [INDEX_W-1:0]                 ov_index;
    logic signed [SAMPLE_W-1:0]         ov_value;
  } item_t;

endpackage

`default_nettype wire

@@ src/jamm_front.sv @@
// Front end: accepts snapshots, finds the active mode, tracks the gripper toggle.
// Depends on jamm_pkg.
`default_nettype none

module jamm_front (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              in_valid,
  input  logic                                              queue_ready,
  input  logic                                              connected,
  input  logic [jamm_pkg::NUM_BUTTONS-1:0]                  buttons,
  input  logic [jamm_pkg::NUM_AXES-1:0][jamm_pkg::SAMPLE_W-1:0] axes,
  input  logic [jamm_pkg::INDEX_W-1:0]                      override_index,
  input  logic signed [jamm_pkg::SAMPLE_W-1:0]              override_value,
  input  logic [jamm_pkg::BTN_W-1:0]                        grip_sel,
  output logic                                              push,
  output jamm_pkg::item_t                                   item
);

  logic gripper_prev_pressed;
  logic gripper_closed;
  logic gripper_closed_next;
  logic grip_now;
  logic mode_valid;
  logic [jamm_pkg::BTN_W-1:0] mode;

  assign push = in_valid && queue_ready;

  // Highest pressed button sets the mode
  always_comb begin
    mode_valid = 1'b0;
    mode       = '0;
    for (int i = 0; i < jamm_pkg::NUM_BUTTONS; i++) begin
      if (buttons[i]) begin
        mode_valid = 1'b1;
        mode       = jamm_pkg::BTN_W'(i);
      end
    end
  end

  // Toggle the gripper on a rising edge of its button
  always_comb begin
    grip_now = ({1'b0, grip_sel} < 5'(jamm_pkg::NUM_BUTTONS)) &&
               buttons[grip_sel];
    gripper_closed_next = gripper_closed ^ (!gripper_prev_pressed && grip_now);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gripper_prev_pressed <= 1'b0;
      gripper_closed       <= 1'b0;
    end else if (push && connected) begin
      gripper_prev_pressed <= grip_now;
      gripper_closed       <= gripper_closed_next;
    end
  end

  // Build the classified item
  always_comb begin
    item.connected   = connected;
    item.mode_valid  = mode_valid;
    item.mode        = mode;
    item.grip_closed = gripper_closed_next;
    item.axes        = axes;
    item.ov_index    = override_index;
    item.ov_value    = override_value;
  end

endmodule

`default_nettype wire

@@ src/jamm_queue.sv @@
// Short item queue between the front end and the back end.
// Depends on jamm_pkg.
`default_nettype none

module jamm_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  jamm_pkg::item_t push_item,
  output logic            ready,
  input  logic            pop,
  output logic            head_valid,
  output jamm_pkg::item_t head
);

  localparam int CNT_W = $clog2(jamm_pkg::QUEUE_DEPTH + 1);

  jamm_pkg::item_t              slots [jamm_pkg::QUEUE_DEPTH];
  logic [jamm_pkg::QPTR_W-1:0]  wr_ptr;
  logic [jamm_pkg::QPTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]             count;

  assign ready      = (count != CNT_W'(jamm_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == jamm_pkg::QPTR_W'(jamm_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == jamm_pkg::QPTR_W'(jamm_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/jamm_back.sv @@
// Back end: walks the vector one entry per cycle while the output is not stalled,
// resolves the mapping, scales and saturates in a two-stage pipeline. Depends on jamm_pkg.
`default_nettype none

module jamm_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [jamm_pkg::DZ_W-1:0]             deadzone,
  input  jamm_pkg::map_table_t                  map_table,
  input  logic                                  head_valid,
  input  jamm_pkg::item_t                       head,
  output logic                                  pop,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [jamm_pkg::INDEX_W-1:0]          vector_index,
  output logic signed [jamm_pkg::SAMPLE_W-1:0]  value,
  output logic                                  last
);

  localparam int W = jamm_pkg::SAMPLE_W;

  logic                         advance;
  logic [jamm_pkg::INDEX_W-1:0] cnt;

  // Stage 1 registers
  logic                         s1_valid;
  logic [jamm_pkg::INDEX_W-1:0] s1_index;
  logic                         s1_last;
  logic                         s1_use_map;
  logic signed [W-1:0]          s1_fixed;
  logic [W-1:0]                 s1_diff;
  logic [W-1:0]                 s1_gmag;
  logic                         s1_neg;

  // Stage 1 next values
  logic                         use_map_next;
  logic signed [W-1:0]          fixed_next;
  logic [W-1:0]                 diff_next;
  logic [W-1:0]                 gmag_next;
  logic                         neg_next;

  // Stage 2 arithmetic
  logic [2*W-1:0]               prod;
  logic [W:0]                   quot;
  logic signed [W-1:0]          scaled;

  assign advance = !out_valid || !out_stall;
  assign pop     = advance && head_valid && (cnt == jamm_pkg::LAST_INDEX);

  // Resolve the entry at cnt: override, disconnect, gripper, then mapping
  always_comb begin
    logic                 found;
    jamm_pkg::map_entry_t sel;
    logic signed [W-1:0]  a;
    logic [W-1:0]         mag;
    found        = 1'b0;
    sel          = '0;
    a            = '0;
    for (int j = 0; j < jamm_pkg::MAP_ENTRIES; j++) begin
      if (map_table[j].valid && head.mode_valid && map_table[j].mode == head.mode &&
          map_table[j].target == cnt) begin
        found = 1'b1;
        sel   = map_table[j];
      end
    end
    if (sel.axis < 3'(jamm_pkg::NUM_AXES)) begin
      a = $signed(head.axes[sel.axis]);
    end
    mag       = a[W-1] ? W'(-a) : W'(a);
    diff_next = mag - W'(deadzone);
    gmag_next = sel.gain[W-1] ? W'(-sel.gain) : W'(sel.gain);
    neg_next  = a[W-1] ^ sel.gain[W-1];
    use_map_next = 1'b0;
    fixed_next   = '0;
    priority if (head.ov_value != '0 && head.ov_index == cnt) begin
      fixed_next = head.ov_value;
    end else if (!head.connected) begin
      fixed_next = '0;
    end else if (cnt == jamm_pkg::GRIP_INDEX) begin
      fixed_next = head.grip_closed ? jamm_pkg::GRIP_CLOSED_VALUE : '0;
    end else if (found && (mag > W'(deadzone))) begin
      use_map_next = 1'b1;
    end else begin
      fixed_next = '0;
    end
  end

  // Step through the vector entries of the head item
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= head_valid;
      if (head_valid) begin
        cnt <= (cnt == jamm_pkg::LAST_INDEX) ? '0 : cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_index   <= cnt;
      s1_last    <= (cnt == jamm_pkg::LAST_INDEX);
      s1_use_map <= use_map_next;
      s1_fixed   <= fixed_next;
      s1_diff    <= diff_next;
      s1_gmag    <= gmag_next;
      s1_neg     <= neg_next;
    end
  end

  // Scale by gain, round toward zero, saturate
  always_comb begin
    prod = s1_diff * s1_gmag;
    quot = prod[2*W-1:W-1];
    if (s1_neg) begin
      scaled = (quot > (W+1)'(32768)) ? $signed(16'h8000) : $signed(W'(-quot));
    end else begin
      scaled = (quot > (W+1)'(32767)) ? $signed(16'h7fff) : $signed(W'(quot));
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      vector_index <= s1_index;
      last         <= s1_last;
      value        <= s1_use_map ? scaled : s1_fixed;
    end
  end

endmodule

`default_nettype wire

@@ src/joystick_axis_mode_mapper_top.sv @@
// Top level of the joystick axis mode mapper: configuration registers,
// front end, item queue and back end. Depends on jamm_pkg, jamm_front, jamm_queue and jamm_back.
//
//   channel | handshake             | payload
//   --------+-----------------------+------------------------------------------
//   in      | in_valid / in_stall   | connected, buttons, axis_0..5, override_*
//   out     | out_valid / out_stall | vector_index, value, last
//   cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Each snapshot yields ten results, one per cycle from the back end sequencer while
// out_stall is low; the first result passes through the queue, the stage 1 registers
// and the output register. A two-entry queue lets new snapshots enter while the back end
// works. Reset clears configuration, queue occupancy, pipeline valids and the
// gripper state; no clearing pass is needed.
// An output stall freezes the back end pipeline; the front stalls only on a full queue.
`default_nettype none

module joystick_axis_mode_mapper_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  connected,
  input  logic [15:0]                           buttons,
  input  logic signed [15:0]                    axis_0,
  input  logic signed [15:0]                    axis_1,
  input  logic signed [15:0]                    axis_2,
  input  logic signed [15:0]                    axis_3,
  input  logic signed [15:0]                    axis_4,
  input  logic signed [15:0]                    axis_5,
  input  logic [3:0]                            override_index,
  input  logic signed [15:0]                    override_value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [3:0]                            vector_index,
  output logic signed [15:0]                    value,
  output logic                                  last,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [jamm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [jamm_pkg::CFG_DATA_W-1:0]       cfg_data
);

  logic [jamm_pkg::DZ_W-1:0]  deadzone;
  logic [jamm_pkg::BTN_W-1:0] grip_sel;
  jamm_pkg::map_table_t       map_table;

  logic [jamm_pkg::NUM_AXES-1:0][jamm_pkg::SAMPLE_W-1:0] axes;
  logic            push;
  logic            queue_ready;
  jamm_pkg::item_t push_item;
  logic            head_valid;
  jamm_pkg::item_t head;
  logic            pop;

  assign cfg_ready = 1'b1;
  assign in_stall  = !queue_ready;

  assign axes[0] = axis_0;
  assign axes[1] = axis_1;
  assign axes[2] = axis_2;
  assign axes[3] = axis_3;
  assign axes[4] = axis_4;
  assign axes[5] = axis_5;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      deadzone  <= '0;
      grip_sel  <= '0;
      map_table <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == jamm_pkg::REG_DEADZONE) begin
        deadzone <= cfg_data[jamm_pkg::DZ_W-1:0];
      end
      if (cfg_index == jamm_pkg::REG_GRIP_SEL) begin
        grip_sel <= cfg_data[jamm_pkg::BTN_W-1:0];
      end
      for (int p = 0; p < jamm_pkg::NUM_PAIRS; p++) begin
        if (cfg_index == jamm_pkg::REG_MAP_PAIR_0 + jamm_pkg::CFG_IDX_W'(p)) begin
          map_table[2*p] <= jamm_pkg::map_entry_t'(cfg_data[31:0]);
          if (2*p + 1 < jamm_pkg::MAP_ENTRIES) begin
            map_table[2*p+1] <= jamm_pkg::map_entry_t'(cfg_data[63:32]);
          end
        end
      end
    end
  end

  jamm_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .queue_ready    (queue_ready),
    .connected      (connected),
    .buttons        (buttons),
    .axes           (axes),
    .override_index (override_index),
    .override_value (override_value),
    .grip_sel       (grip_sel),
    .push           (push),
    .item           (push_item)
  );

  jamm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .ready      (queue_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  jamm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .deadzone     (deadzone),
    .map_table    (map_table),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .vector_index (vector_index),
    .value        (value),
    .last         (last)
  );

endmodule

`default_nettype wire

@@ src/jamm_checker.sv @@
// Port-level checker for the joystick axis mode mapper, bound to the top level.
// Depends on jamm_pkg.
`default_nettype none

module jamm_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [3:0]                       vector_index,
  input  logic signed [15:0]               value,
  input  logic                             last
);

  logic [3:0] expect_index;

  // Track which entry the next result must carry
  always_ff @(posedge clk) begin
    if (rst) begin
      expect_index <= '0;
    end else if (out_valid && !out_stall) begin
      expect_index <= last ? '0 : expect_index + 1'b1;
    end
  end

  // Results leave in entry order
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> vector_index == expect_index)
    else $error("result out of entry order");

  // Last marks exactly the final entry
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (vector_index == jamm_pkg::LAST_INDEX)))
    else $error("last flag mismatch");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(vector_index) && $stable(value))
    else $error("stalled result changed");

  // Reset empties the output
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

endmodule

bind joystick_axis_mode_mapper_top jamm_checker u_checker (.*);

`default_nettype wire

@@ dv/jamm_tb_pkg.sv @@
`timescale 1ns / 1ps
// Snapshot and vector entry types plus the motion vector predictor for the mapper bench.
// Depends on jamm_pkg for block dimensions, register indexes and the mapping entry layout.

package jamm_tb_pkg;
  import jamm_pkg::*;

  // One joystick poll as driven on the input channel
  typedef struct packed {
    logic                              connected;
    logic [NUM_BUTTONS-1:0]            buttons;
    logic [NUM_AXES-1:0][SAMPLE_W-1:0] axes;
    logic [INDEX_W-1:0]                ov_index;
    logic signed [SAMPLE_W-1:0]        ov_value;
  } snapshot_t;

  // One motion vector entry as seen on the output channel
  typedef struct packed {
    logic [INDEX_W-1:0]         index;
    logic signed [SAMPLE_W-1:0] value;
    logic                       last;
  } vector_entry_t;

  class motion_vector_model;
    logic [DZ_W-1:0]  deadzone;
    logic [BTN_W-1:0] grip_button;
    map_table_t       mapping;
    logic             grip_prev;
    logic             grip_closed;
    vector_entry_t    pending_entries[$];
    int               mismatches;
    int               checked;
    int               accepted;
    int               toggles;

    function new();
      deadzone    = '0;
      grip_button = '0;
      mapping     = '0;
      grip_prev   = 1'b0;
      grip_closed = 1'b0;
      mismatches  = 0;
      checked     = 0;
      accepted    = 0;
      toggles     = 0;
    endfunction

    // Mirror a register write; data bits above the register width are dropped
    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      int p;
      if (idx == REG_DEADZONE) begin
        deadzone = data[DZ_W-1:0];
      end else if (idx == REG_GRIP_SEL) begin
        grip_button = data[BTN_W-1:0];
      end else if (int'(idx) >= int'(REG_MAP_PAIR_0) &&
                   int'(idx) < int'(REG_MAP_PAIR_0) + NUM_PAIRS) begin
        p = int'(idx) - int'(REG_MAP_PAIR_0);
        mapping[2*p]     = map_entry_t'(data[31:0]);
        mapping[2*p + 1] = map_entry_t'(data[63:32]);
      end
    endfunction

    // Deadzone, scale by gain/32768 toward zero, saturate to 16 bits
    function int scaled_axis(int sample, int gain);
      int     mag;
      int     gmag;
      longint prod;
      longint q;
      mag = (sample < 0) ? -sample : sample;
      if (mag <= int'(deadzone)) return 0;
      gmag = (gain < 0) ? -gain : gain;
      prod = longint'(mag - int'(deadzone)) * longint'(gmag);
      q    = prod >>> 15;
      if ((sample < 0) != (gain < 0)) return (q > 32768) ? -32768 : -int'(q);
      return (q > 32767) ? 32767 : int'(q);
    endfunction

    // Work out the full vector for an accepted snapshot and queue its entries
    function void note_snapshot(snapshot_t s);
      int            vec[VECTOR_LEN];
      int            mode;
      int            sample;
      logic          grip_now;
      map_entry_t    e;
      vector_entry_t ent;
      accepted++;
      foreach (vec[i]) vec[i] = 0;
      if (s.connected) begin
        mode = -1;
        for (int b = 0; b < NUM_BUTTONS; b++) if (s.buttons[b]) mode = b;
        for (int m = 0; m < MAP_ENTRIES; m++) begin
          e = mapping[m];
          if (e.valid && mode >= 0 && int'(e.mode) == mode && int'(e.target) < VECTOR_LEN) begin
            sample = 0;
            if (int'(e.axis) < NUM_AXES) sample = int'($signed(s.axes[e.axis]));
            vec[e.target] = scaled_axis(sample, int'($signed(e.gain)));
          end
        end
        // Toggle the gripper on a rising edge of its button
        grip_now = s.buttons[grip_button];
        if (!grip_prev && grip_now) begin
          grip_closed = !grip_closed;
          toggles++;
        end
        grip_prev = grip_now;
        vec[GRIP_INDEX] = grip_closed ? int'(GRIP_CLOSED_VALUE) : 0;
      end
      if (s.ov_value != 0 && int'(s.ov_index) < VECTOR_LEN)
        vec[s.ov_index] = int'($signed(s.ov_value));
      for (int i = 0; i < VECTOR_LEN; i++) begin
        ent.index = INDEX_W'(i);
        ent.value = SAMPLE_W'(vec[i]);
        ent.last  = (i == VECTOR_LEN - 1);
        pending_entries.insert(pending_entries.size(), ent);
      end
    endfunction

    // Compare one output entry against the oldest queued one
    function void check_entry(vector_entry_t got);
      vector_entry_t want;
      if (pending_entries.size() == 0) begin
        if (mismatches < 40)
          $display("%0t: unexpected entry: index %0d value %0d last %0d", $time,
                   got.index, $signed(got.value), got.last);
        mismatches++;
        return;
      end
      want = pending_entries.pop_front();
      checked++;
      if (got.index !== want.index) begin
        if (mismatches < 40)
          $display("%0t: vector_index expected %0d actual %0d", $time, want.index, got.index);
        mismatches++;
      end
      if (got.value !== want.value) begin
        if (mismatches < 40)
          $display("%0t: value at entry %0d expected %0d actual %0d", $time, want.index,
                   $signed(want.value), $signed(got.value));
        mismatches++;
      end
      if (got.last !== want.last) begin
        if (mismatches < 40)
          $display("%0t: last at entry %0d expected %0d actual %0d", $time, want.index,
                   want.last, got.last);
        mismatches++;
      end
    endfunction

    function int pending();
      return pending_entries.size();
    endfunction
  endclass

endpackage

@@ dv/tb_joystick_axis_mode_mapper_top.sv @@
`timescale 1ns / 1ps
// Bench for joystick_axis_mode_mapper_top: directed polls, then random polls under varied idling.
// Depends on jamm_pkg, jamm_tb_pkg and the block's RTL.

module tb_joystick_axis_mode_mapper_top;
  import jamm_pkg::*;
  import jamm_tb_pkg::*;

  localparam int CYCLE_LIMIT       = 300000;
  localparam int RANDOM_SEGMENTS   = 6;
  localparam int ITEMS_PER_SEGMENT = 42;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   in_valid;
  logic                   in_stall;
  logic                   connected;
  logic [15:0]            buttons;
  logic signed [15:0]     axis_0, axis_1, axis_2, axis_3, axis_4, axis_5;
  logic [3:0]             override_index;
  logic signed [15:0]     override_value;
  logic                   out_valid;
  logic                   out_stall;
  logic [3:0]             vector_index;
  logic signed [15:0]     value;
  logic                   last;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  motion_vector_model     model;
  int                     tx_idle_pct;
  int                     rx_stall_pct;
  int                     cycle_count;
  int                     reg_writes;
  int                     settings_used;
  int                     directed_count;

  // Current register image and the modes that random polls aim at
  logic [DZ_W-1:0]        cfg_deadzone;
  logic [BTN_W-1:0]       cfg_grip;
  logic [CFG_DATA_W-1:0]  cfg_pairs[NUM_PAIRS];
  int                     active_modes[3];

  // Output side sampled between edges
  bit                     take_result;
  vector_entry_t          seen_entry;

  joystick_axis_mode_mapper_top dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .connected      (connected),
    .buttons        (buttons),
    .axis_0         (axis_0),
    .axis_1         (axis_1),
    .axis_2         (axis_2),
    .axis_3         (axis_3),
    .axis_4         (axis_4),
    .axis_5         (axis_5),
    .override_index (override_index),
    .override_value (override_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .vector_index   (vector_index),
    .value          (value),
    .last           (last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sample the output channel mid-cycle, when everything has settled
  always @(negedge clk) begin
    take_result        = !rst && out_valid && !out_stall;
    seen_entry.index   = vector_index;
    seen_entry.value   = value;
    seen_entry.last    = last;
  end

  // Check the item taken at this edge, then pick the next stall
  always @(posedge clk) begin
    if (take_result) model.check_entry(seen_entry);
    out_stall <= ($urandom_range(99) < rx_stall_pct);
  end

  // Hard stop on a hung run
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d entries still owed", cycle_count, model.pending());
    $display("FAILED: results differ");
    $finish;
  end

  function automatic logic [31:0] make_entry(bit v, int mode, int axis, int target, int gain,
                                             int spare = 0);
    map_entry_t e;
    e.valid  = v;
    e.mode   = BTN_W'(mode);
    e.axis   = 3'(axis);
    e.target = INDEX_W'(target);
    e.gain   = SAMPLE_W'(gain);
    e.spare  = 4'(spare);
    return e;
  endfunction

  function automatic snapshot_t snap(bit conn, logic [15:0] btn, int a0, int a1, int a2, int a3,
                                     int a4, int a5, int ovi, int ovv);
    snapshot_t s;
    s.connected = conn;
    s.buttons   = btn;
    s.axes[0]   = SAMPLE_W'(a0);
    s.axes[1]   = SAMPLE_W'(a1);
    s.axes[2]   = SAMPLE_W'(a2);
    s.axes[3]   = SAMPLE_W'(a3);
    s.axes[4]   = SAMPLE_W'(a4);
    s.axes[5]   = SAMPLE_W'(a5);
    s.ov_index  = INDEX_W'(ovi);
    s.ov_value  = SAMPLE_W'(ovv);
    return s;
  endfunction

  // Mix of extremes, values around the deadzone, small and full-range samples
  function automatic logic [SAMPLE_W-1:0] random_sample();
    int v;
    case ($urandom_range(3))
      0: v = $urandom_range(1) ? 32767 : -32768;
      1: begin
        v = int'(cfg_deadzone) + int'($urandom_range(4)) - 2;
        if (v < 0) v = 0;
        if (v > 32767) v = 32767;
        if ($urandom_range(1)) v = -v;
      end
      2: v = int'($urandom_range(2048)) - 1024;
      default: v = int'($urandom);
    endcase
    return SAMPLE_W'(v);
  endfunction

  function automatic int random_gain();
    case ($urandom_range(3))
      0: return $urandom_range(1) ? 32767 : -32768;
      1: return int'($urandom_range(1024)) - 512;
      2: return int'($urandom_range(768));
      default: return int'($signed(16'($urandom)));
    endcase
  endfunction

  function automatic logic [31:0] random_entry();
    int mode;
    int target;
    mode   = ($urandom_range(9) == 0) ? int'($urandom_range(15)) : active_modes[$urandom_range(2)];
    target = ($urandom_range(99) < 85) ? int'($urandom_range(9)) : int'($urandom_range(15, 10));
    return make_entry($urandom_range(99) < 85, mode, $urandom_range(7), target, random_gain(),
                      $urandom_range(15));
  endfunction

  // Draw a fresh register image; early and late segments pin the deadzone extremes
  function automatic void pick_config(int seg);
    case (seg)
      0: cfg_deadzone = '0;
      RANDOM_SEGMENTS - 1: cfg_deadzone = '1;
      default: case ($urandom_range(2))
        0: cfg_deadzone = DZ_W'($urandom_range(2000));
        1: cfg_deadzone = DZ_W'($urandom_range(300));
        default: cfg_deadzone = DZ_W'($urandom_range(32767));
      endcase
    endcase
    if (seg == 1) cfg_grip = BTN_W'(NUM_BUTTONS - 1);
    else if (seg == 2) cfg_grip = '0;
    else cfg_grip = BTN_W'($urandom_range(15));
    foreach (active_modes[i]) active_modes[i] = $urandom_range(15);
    foreach (cfg_pairs[p]) cfg_pairs[p] = {random_entry(), random_entry()};
  endfunction

  // Mostly polls whose top button selects a configured mode, plus noise
  function automatic snapshot_t random_snapshot();
    snapshot_t s;
    int        m;
    s.connected = ($urandom_range(9) != 0);
    case ($urandom_range(9))
      0: s.buttons = '0;
      1, 2: s.buttons = 16'($urandom);
      default: begin
        m = active_modes[$urandom_range(2)];
        s.buttons = (16'(1) << m) | (16'($urandom) & ((16'(1) << m) - 16'(1)));
      end
    endcase
    if ($urandom_range(1)) s.buttons[cfg_grip] = $urandom_range(1);
    for (int i = 0; i < NUM_AXES; i++) s.axes[i] = random_sample();
    s.ov_index = INDEX_W'($urandom_range(VECTOR_LEN - 1));
    s.ov_value = '0;
    if ($urandom_range(3) == 0) begin
      if ($urandom_range(4) == 0) s.ov_value = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      else s.ov_value = 16'($urandom);
      if (s.ov_value == 0) s.ov_value = 16'sd1;
    end
    return s;
  endfunction

  // Offer one poll, with random idle cycles ahead of it; returns at the accepting edge
  task automatic send_snapshot(snapshot_t s);
    bit go;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    connected      <= s.connected;
    buttons        <= s.buttons;
    axis_0         <= s.axes[0];
    axis_1         <= s.axes[1];
    axis_2         <= s.axes[2];
    axis_3         <= s.axes[3];
    axis_4         <= s.axes[4];
    axis_5         <= s.axes[5];
    override_index <= s.ov_index;
    override_value <= s.ov_value;
    do begin
      @(negedge clk);
      go = !in_stall;
      @(posedge clk);
    end while (!go);
    model.note_snapshot(s);
  endtask

  // Hold the input idle until every queued entry has come out
  task automatic drain_vectors();
    in_valid <= 1'b0;
    do @(posedge clk); while (model.pending() != 0);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    bit go;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do begin
      @(negedge clk);
      go = cfg_ready;
      @(posedge clk);
    end while (!go);
    model.set_register(idx, data);
    reg_writes++;
  endtask

  // Write the whole register image, with junk above the narrow registers
  task automatic program_registers();
    logic [CFG_DATA_W-1:0] data;
    data = {$urandom, $urandom};
    data[DZ_W-1:0] = cfg_deadzone;
    write_register(REG_DEADZONE, data);
    data = {$urandom, $urandom};
    data[BTN_W-1:0] = cfg_grip;
    write_register(REG_GRIP_SEL, data);
    for (int p = 0; p < NUM_PAIRS; p++)
      write_register(CFG_IDX_W'(int'(REG_MAP_PAIR_0) + p), cfg_pairs[p]);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  initial begin
    model          = new();
    reg_writes     = 0;
    settings_used  = 0;
    directed_count = 0;
    tx_idle_pct    = 37;
    rx_stall_pct   = 84;
    rst            <= 1'b1;
    in_valid       <= 1'b0;
    connected      <= 1'b0;
    buttons        <= '0;
    axis_0         <= '0;
    axis_1         <= '0;
    axis_2         <= '0;
    axis_3         <= '0;
    axis_4         <= '0;
    axis_5         <= '0;
    override_index <= '0;
    override_value <= '0;
    out_stall      <= 1'b0;
    cfg_valid      <= 1'b0;
    cfg_index      <= '0;
    cfg_data       <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset image: no valid entries, gripper on button 0
    send_snapshot(snap(1, 16'hFFFF, 32767, -32768, 1, -1, 0, 12345, 0, 0));
    send_snapshot(snap(0, 16'h0000, -5, 5, 0, 0, 0, 0, 4, -7));
    directed_count += 2;

    // Directed table: overlapping targets, out-of-range axis and target, an invalid entry,
    // an entry aimed at the gripper slot and gain extremes
    drain_vectors();
    cfg_deadzone = '0;
    cfg_grip     = 4'd3;
    cfg_pairs[0] = {make_entry(1, 5, 1, 1, -256),    make_entry(1, 5, 0, 0, 256)};
    cfg_pairs[1] = {make_entry(1, 5, 3, 2, 128),     make_entry(1, 5, 2, 2, 32767)};
    cfg_pairs[2] = {make_entry(1, 7, 6, 12, 256),    make_entry(1, 7, 7, 3, 256)};
    cfg_pairs[3] = {make_entry(1, 15, 5, 9, -32768), make_entry(0, 5, 5, 4, 256)};
    cfg_pairs[4] = {make_entry(1, 15, 0, 8, 32767, 15), make_entry(1, 0, 5, 5, -32768)};
    program_registers();
    send_snapshot(snap(1, 16'h0020, 32767, -32768, -32768, 100, 0, 0, 0, 0));
    send_snapshot(snap(1, 16'h0028, -1, 1, 32767, -32768, 5, 5, 0, 0));
    send_snapshot(snap(1, 16'h0028, 200, 300, 400, 500, 600, 700, 0, 0));
    send_snapshot(snap(1, 16'h0020, -200, -300, -400, -500, -600, -700, 0, 0));
    send_snapshot(snap(1, 16'h0008, 1000, 1000, 1000, 1000, 1000, 1000, 0, 0));
    send_snapshot(snap(0, 16'hFFFF, 32767, 32767, 32767, 32767, 32767, 32767, 9, 32767));
    send_snapshot(snap(1, 16'h00A0, 32767, -32768, 32767, -32768, 32767, -32768, 0, -32768));
    send_snapshot(snap(1, 16'hFFFF, -32768, 0, 0, 0, 0, 32767, 0, 0));
    send_snapshot(snap(1, 16'h0001, 0, 0, 0, 0, 0, -32768, 5, 0));
    send_snapshot(snap(1, 16'h0001, 0, 0, 0, 0, 0, 32767, 3, 1));
    send_snapshot(snap(1, 16'h0000, 32767, 32767, 32767, 32767, 32767, 32767, 9, -1));
    send_snapshot(snap(1, 16'h8000, 1234, -1234, 0, 0, 0, 4321, 8, 0));
    directed_count += 12;

    // Deadzone edges, gripper on the top button
    drain_vectors();
    cfg_deadzone = 15'd1000;
    cfg_grip     = 4'd15;
    program_registers();
    send_snapshot(snap(1, 16'h0020, 1000, -1000, 1001, -1001, 0, 0, 0, 0));
    send_snapshot(snap(1, 16'h8020, 999, -999, 32767, -32768, 0, 0, 1, 256));
    directed_count += 2;

    // Largest deadzone: only a full negative swing gets through
    drain_vectors();
    cfg_deadzone = '1;
    cfg_grip     = 4'd0;
    program_registers();
    send_snapshot(snap(1, 16'h0021, -32768, 32767, -32768, -32768, 0, 0, 0, 0));
    send_snapshot(snap(1, 16'h0020, -32768, -32768, -32768, -32768, -32768, -32768, 9, -1));
    directed_count += 2;

    // Random segments: two per idling pattern, fresh registers each time
    for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
      drain_vectors();
      case (seg / 2)
        0: begin tx_idle_pct = 37; rx_stall_pct = 84; end
        1: begin tx_idle_pct = 84; rx_stall_pct = 37; end
        default: begin tx_idle_pct = 0; rx_stall_pct = 0; end
      endcase
      pick_config(seg);
      program_registers();
      for (int n = 0; n < ITEMS_PER_SEGMENT; n++) begin
        // Let the output run dry once per segment before carrying on
        if (n == ITEMS_PER_SEGMENT / 2) drain_vectors();
        send_snapshot(random_snapshot());
      end
    end

    drain_vectors();
    repeat (20) @(posedge clk);
    $display("Sent %0d polls (%0d directed) over %0d register settings, %0d register writes;",
             model.accepted, directed_count, settings_used, reg_writes);
    $display("checked %0d vector entries, saw %0d gripper toggles.", model.checked,
             model.toggles);
    if (model.mismatches == 0 && model.pending() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
